>>> rtl/kmsc_pkg.sv
// kmsc_pkg: shared types and constants of the k-mer seed counter.
// No dependencies; imported by every rtl module of the block except kmsc_ram.
package kmsc_pkg;

  localparam int TABLE_AW    = 16;
  localparam int TABLE_DEPTH = 65536;
  localparam int COUNT_W     = 32;
  localparam int POS_W       = 32;
  localparam int RUN_W       = 4;

  localparam logic [RUN_W-1:0]   RUN_MAX   = 4'd15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  // transaction kinds carried on in_tuser
  typedef enum logic [1:0] {
    MODE_LETTER   = 2'd0,
    MODE_MASK_WR  = 2'd1,
    MODE_COUNT_RD = 2'd2
  } mode_t;

  // stage 0 -> stage 1 request
  typedef struct packed {
    logic                valid;
    mode_t               mode;
    logic [TABLE_AW-1:0] addr;
    logic                count_ok;
    logic [POS_W-1:0]    wstart;
    logic                mval;
  } req_t;

  // one result item
  typedef struct packed {
    logic                seed_valid;
    logic [TABLE_AW-1:0] seed_code;
    logic [POS_W-1:0]    window_start;
    logic [COUNT_W-1:0]  count_value;
    logic                present_bit;
  } result_t;

endpackage

>>> rtl/kmsc_ram.sv
// kmsc_ram: generic single-write, single-read synchronous RAM.
// Registered read, read-during-write returns old data. No dependencies.
module kmsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/kmsc_front.sv
// kmsc_front: stage 0, rolling code, good-letter run and position registers.
// Builds the table request for stage 1. Depends on kmsc_pkg.
module kmsc_front #(
  parameter int SEED_SPAN = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [1:0]                    mode,
  input  logic                          seq_first,
  input  logic [1:0]                    base,
  input  logic                          bad_letter,
  input  logic [kmsc_pkg::TABLE_AW-1:0] table_code,
  input  logic                          mask_value,
  output kmsc_pkg::req_t                req
);
  import kmsc_pkg::*;

  localparam int CW = 2 * SEED_SPAN;
  localparam logic [RUN_W-1:0] SPAN_RUN = RUN_W'(SEED_SPAN);
  localparam logic [POS_W-1:0] SPAN_OFS = POS_W'(SEED_SPAN - 1);

  logic [CW-1:0]    code_r, code_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic                   is_letter;
  logic [POS_W-1:0]       pos_base;
  logic [RUN_W-1:0]       run_base, run_l;
  logic [CW+1:0]          shift_word;
  logic [CW-1:0]          code_l;
  logic [CW+TABLE_AW-1:0] code_ext;

  always_comb begin
    is_letter  = (mode == MODE_LETTER);
    pos_base   = seq_first ? '0 : pos_r;
    run_base   = seq_first ? '0 : run_r;
    // newest base enters at the top
    shift_word = {base, code_r};
    code_l     = shift_word[CW+1:2];
    code_ext   = {{TABLE_AW{1'b0}}, code_l};
    if (bad_letter) begin
      run_l = '0;
    end else if (run_base != RUN_MAX) begin
      run_l = run_base + 1'b1;
    end else begin
      run_l = run_base;
    end

    req.valid    = accept;
    req.mode     = mode_t'(mode);
    req.addr     = is_letter ? code_ext[TABLE_AW-1:0] : table_code;
    req.count_ok = is_letter && !bad_letter && (run_l >= SPAN_RUN);
    req.wstart   = pos_base - SPAN_OFS;
    req.mval     = mask_value;

    code_nxt = code_r;
    run_nxt  = run_r;
    pos_nxt  = pos_r;
    if (accept && is_letter) begin
      code_nxt = code_l;
      run_nxt  = run_l;
      pos_nxt  = pos_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
      run_r  <= '0;
      pos_r  <= '0;
    end else begin
      code_r <= code_nxt;
      run_r  <= run_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

>>> rtl/kmsc_update.sv
// kmsc_update: stage 1, mask and counter RAMs, read-modify-write with
// forwarding, and the clearing pass after reset. Depends on kmsc_pkg, kmsc_ram.
module kmsc_update (
  input  logic              clk,
  input  logic              rst_n,
  input  kmsc_pkg::req_t    req,
  output logic              res_valid,
  output kmsc_pkg::result_t res,
  output logic              clearing
);
  import kmsc_pkg::*;

  logic                clr_busy_r, clr_busy_nxt;
  logic [TABLE_AW-1:0] clr_addr_r, clr_addr_nxt;

  logic s1_valid_r;
  req_t s1_r;

  // last stage-1 write to each RAM (RAM read misses a same-edge write)
  logic                cfw_v_r;
  logic [TABLE_AW-1:0] cfw_addr_r;
  logic [COUNT_W-1:0]  cfw_data_r;
  logic                mfw_v_r;
  logic [TABLE_AW-1:0] mfw_addr_r;
  logic                mfw_data_r;

  logic                cnt_we, mask_we;
  logic [TABLE_AW-1:0] cnt_waddr, mask_waddr;
  logic [COUNT_W-1:0]  cnt_wdata, cnt_rdata, cnt_cur, cnt_inc;
  logic                mask_wdata, mask_rdata, mask_cur;
  logic                seed_hit, s1_cnt_we, s1_mask_we;

  kmsc_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_DEPTH)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (req.valid),
    .raddr (req.addr),
    .rdata (cnt_rdata)
  );

  kmsc_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .re    (req.valid),
    .raddr (req.addr),
    .rdata (mask_rdata)
  );

  always_comb begin
    cnt_cur  = (cfw_v_r && cfw_addr_r == s1_r.addr) ? cfw_data_r : cnt_rdata;
    mask_cur = (mfw_v_r && mfw_addr_r == s1_r.addr) ? mfw_data_r : mask_rdata;
    cnt_inc  = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

    seed_hit   = s1_valid_r && (s1_r.mode == MODE_LETTER) && s1_r.count_ok && mask_cur;
    s1_cnt_we  = seed_hit;
    s1_mask_we = s1_valid_r && (s1_r.mode == MODE_MASK_WR);

    if (clr_busy_r) begin
      cnt_we     = 1'b1;
      cnt_waddr  = clr_addr_r;
      cnt_wdata  = '0;
      mask_we    = 1'b1;
      mask_waddr = clr_addr_r;
      mask_wdata = 1'b1;
    end else begin
      cnt_we     = s1_cnt_we;
      cnt_waddr  = s1_r.addr;
      cnt_wdata  = cnt_inc;
      mask_we    = s1_mask_we;
      mask_waddr = s1_r.addr;
      mask_wdata = s1_r.mval;
    end

    res = '0;
    case (s1_r.mode)
      MODE_LETTER: begin
        res.seed_valid   = seed_hit;
        res.seed_code    = s1_r.addr;
        res.window_start = seed_hit ? s1_r.wstart : '0;
      end
      MODE_COUNT_RD: begin
        res.count_value = cnt_cur;
        res.present_bit = (cnt_cur != '0) && mask_cur;
      end
      default: begin
        res = '0;
      end
    endcase
    res_valid = s1_valid_r;
    clearing  = clr_busy_r;

    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == {TABLE_AW{1'b1}}) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      s1_valid_r <= 1'b0;
      cfw_v_r    <= 1'b0;
      mfw_v_r    <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      s1_valid_r <= req.valid;
      if (s1_cnt_we) begin
        cfw_v_r <= 1'b1;
      end
      if (s1_mask_we) begin
        mfw_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      s1_r <= req;
    end
    if (s1_cnt_we) begin
      cfw_addr_r <= s1_r.addr;
      cfw_data_r <= cnt_inc;
    end
    if (s1_mask_we) begin
      mfw_addr_r <= s1_r.addr;
      mfw_data_r <= s1_r.mval;
    end
  end

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> !clr_busy_r)
    else $error("request issued during clearing pass");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r |=> !clr_busy_r)
    else $error("clearing pass restarted without reset");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!clr_busy_r && cnt_we) |-> (cnt_wdata != '0))
    else $error("counter update wrote zero");

endmodule

>>> rtl/kmsc_outq.sv
// kmsc_outq: four-entry result queue between stage 1 and the master side.
// Depends on kmsc_pkg.
module kmsc_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kmsc_pkg::result_t push_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kmsc_pkg::result_t out_data,
  output logic [2:0]        level
);
  import kmsc_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  result_t          slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             pop;

  always_comb begin
    out_valid = (cnt_r != 3'd0);
    out_data  = slot_r[rd_ptr_r];
    pop       = out_valid && out_ready;
    level     = cnt_r;
    cnt_nxt   = cnt_r + {2'b00, push} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 3'd4))
    else $error("result queue overflow");

endmodule

>>> rtl/kmer_seed_counter.sv
// kmer_seed_counter: top level of the rolling 2-bit k-mer seed counter.
// Path: stage 1 registers an accepted transaction; out_* shows its result from the queue.
// Throughput: one transaction per cycle while in_tready is high; the counter RAM
//   read-modify-write uses a one-entry forwarding register per RAM.
// Reset: rst_n low clears the pipeline; afterwards a clearing pass over all 65536
//   table entries sets every mask bit and zeroes every counter, in_tready held low.
module kmer_seed_counter #(
  parameter int SEED_SPAN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // slave side
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: [0] seq_first, [2:1] base, [3] bad_letter,
  //           [19:4] table_code, [20] mask_value, [23:21] zero
  input  logic [23:0] in_tdata,
  // in_tuser: [1:0] mode
  input  logic [1:0]  in_tuser,
  // master side
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: [0] seed_valid, [16:1] seed_code, [48:17] window_start,
  //            [80:49] count_value, [81] present_bit, [87:82] zero
  output logic [87:0] out_tdata
);
  import kmsc_pkg::*;

  logic       in_accept;
  req_t       req;
  logic       res_valid;
  result_t    res, q_data;
  logic       clearing;
  logic [2:0] q_level;
  logic [2:0] in_flight;

  // at most three items in stage 1 plus the queue; the queue never stalls stage 1
  always_comb begin
    in_flight = {2'b00, res_valid} + q_level;
    in_tready = !clearing && (in_flight < 3'd3);
    in_accept = in_tvalid && in_tready;
  end

  kmsc_front #(.SEED_SPAN(SEED_SPAN)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .mode       (in_tuser),
    .seq_first  (in_tdata[0]),
    .base       (in_tdata[2:1]),
    .bad_letter (in_tdata[3]),
    .table_code (in_tdata[19:4]),
    .mask_value (in_tdata[20]),
    .req        (req)
  );

  // stage 1: table access, counter update, result forming
  kmsc_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .clearing  (clearing)
  );

  kmsc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data),
    .level     (q_level)
  );

  assign out_tdata = {6'b000000, q_data.present_bit, q_data.count_value,
                      q_data.window_start, q_data.seed_code, q_data.seed_valid};

  a_ready_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (q_level + {2'b00, res_valid}) <= 3'd3)
    else $error("items in flight exceed queue room");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("input ready during clearing pass");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> res_valid)
    else $error("accepted transaction produced no result");

endmodule
